@@ rtl/spv_esd_pkg.sv @@
package spv_esd_pkg;

  // Fixed values of the module format.
  localparam logic [31:0] MagicWord    = 32'h0723_0203;
  localparam logic [7:0]  OpEntryPoint = 8'd15;
  localparam logic [2:0]  HeaderWords  = 3'd5;
  localparam logic [31:0] ModelMax     = 32'd5;

  // Parser phases.
  typedef enum logic [1:0] {
    PH_HEADER,
    PH_WALK,
    PH_MODEL
  } phase_t;

  // Stage codes given on the result.
  typedef enum logic [2:0] {
    STAGE_UNKNOWN  = 3'd0,
    STAGE_VERTEX   = 3'd1,
    STAGE_TESS_CTL = 3'd2,
    STAGE_TESS_EVL = 3'd3,
    STAGE_GEOMETRY = 3'd4,
    STAGE_FRAGMENT = 3'd5,
    STAGE_COMPUTE  = 3'd6
  } stage_t;

  // One word of the module as it moves between stages.
  typedef struct packed {
    logic        valid;
    logic [31:0] word;
    logic        last;
  } word_item_t;

  // What the parser hands to the result register.
  typedef struct packed {
    logic   emit;
    stage_t stage;
  } parse_res_t;

endpackage

@@ rtl/spirv_entry_stage_detect.sv @@
// Channel   Signals                              Direction  Content
// code      code_valid, code_stall, code_word,  in         one module word, last flag
//           last_word
// stage     stage_valid, stage_stall,           out        one stage code per module
//           shader_stage
//
// A word is taken every cycle unless stalled; any result is offered by the result register.
// The rate is set by the single parser stage, which updates its phase and skip counter per word.
// Reset is synchronous and returns the parser to the header phase awaiting the magic word.
// A stalled result holds the pipeline; the input register still fills once before code_stall.
module spirv_entry_stage_detect
  import spv_esd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        code_valid,
  output logic        code_stall,
  input  logic [31:0] code_word,
  input  logic        last_word,
  output logic        stage_valid,
  input  logic        stage_stall,
  output logic [2:0]  shader_stage
);

  word_item_t item;
  parse_res_t res;
  logic       advance;
  logic       take;

  // A word in the input register is parsed when the pipeline moves.
  assign take = item.valid && advance;

  spv_esd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .code_valid (code_valid),
    .code_word  (code_word),
    .last_word  (last_word),
    .advance    (advance),
    .code_stall (code_stall),
    .item       (item)
  );

  spv_esd_walk u_walk (
    .clk  (clk),
    .rst  (rst),
    .item (item),
    .take (take),
    .res  (res)
  );

  spv_esd_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .res          (res),
    .stage_stall  (stage_stall),
    .advance      (advance),
    .stage_valid  (stage_valid),
    .shader_stage (shader_stage)
  );

endmodule

@@ rtl/spv_esd_in_reg.sv @@
module spv_esd_in_reg
  import spv_esd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        code_valid,
  input  logic [31:0] code_word,
  input  logic        last_word,
  input  logic        advance,
  output logic        code_stall,
  output word_item_t  item
);

  // The register holds its word only while the pipeline cannot move.
  assign code_stall = item.valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item.valid <= 1'b0;
    end else if (!code_stall) begin
      item.valid <= code_valid;
    end
    if (!code_stall) begin
      item.word <= code_word;
      item.last <= last_word;
    end
  end

endmodule

@@ rtl/spv_esd_walk.sv @@
module spv_esd_walk
  import spv_esd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  word_item_t item,
  input  logic       take,
  output parse_res_t res
);

  phase_t      phase, phase_next;
  logic [2:0]  header_index, header_index_next;
  logic [15:0] words_to_skip, words_to_skip_next;
  logic        result_given, result_given_next;
  logic [15:0] len;
  logic [2:0]  hdr_inc;

  assign len     = item.word[31:16];
  assign hdr_inc = header_index + 3'd1;

  // Per-word decision by phase: header check, operand skip, entry point search, model decode.
  always_comb begin
    phase_next         = phase;
    header_index_next  = header_index;
    words_to_skip_next = words_to_skip;
    result_given_next  = result_given;
    res.emit           = 1'b0;
    res.stage          = STAGE_UNKNOWN;
    if (!result_given) begin
      unique case (phase)
        PH_HEADER: begin
          if (header_index == 3'd0 && item.word != MagicWord) begin
            res.emit = 1'b1;
          end else if (item.last) begin
            res.emit = 1'b1;
          end else begin
            header_index_next = hdr_inc;
            if (hdr_inc >= HeaderWords) begin
              phase_next         = PH_WALK;
              words_to_skip_next = 16'd0;
            end
          end
        end
        PH_MODEL: begin
          res.emit = 1'b1;
          if (item.word <= ModelMax) begin
            res.stage = stage_t'(item.word[2:0] + 3'd1);
          end
        end
        default: begin
          if (words_to_skip != 16'd0) begin
            words_to_skip_next = words_to_skip - 16'd1;
            res.emit           = item.last;
          end else if (item.word[7:0] == OpEntryPoint) begin
            if (item.last) begin
              res.emit = 1'b1;
            end else begin
              phase_next = PH_MODEL;
            end
          end else if (len == 16'd0 || item.last) begin
            res.emit = 1'b1;
          end else begin
            words_to_skip_next = len - 16'd1;
          end
        end
      endcase
      if (res.emit) begin
        result_given_next = 1'b1;
      end
    end
    // The last word of a module always rearms the parser.
    if (item.last) begin
      phase_next         = PH_HEADER;
      header_index_next  = 3'd0;
      words_to_skip_next = 16'd0;
      result_given_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      header_index  <= 3'd0;
      words_to_skip <= 16'd0;
      result_given  <= 1'b0;
    end else if (take) begin
      phase         <= phase_next;
      header_index  <= header_index_next;
      words_to_skip <= words_to_skip_next;
      result_given  <= result_given_next;
    end
  end

endmodule

@@ rtl/spv_esd_out_reg.sv @@
module spv_esd_out_reg
  import spv_esd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  parse_res_t res,
  input  logic       stage_stall,
  output logic       advance,
  output logic       stage_valid,
  output logic [2:0] shader_stage
);

  // The pipeline moves whenever the result register is free or being emptied.
  assign advance = !(stage_valid && stage_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (advance) begin
      stage_valid <= take && res.emit;
    end
    if (advance) begin
      shader_stage <= res.stage;
    end
  end

endmodule

@@ rtl/spv_esd_checker.sv @@
module spv_esd_checker
  import spv_esd_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        code_valid,
  input logic        code_stall,
  input logic [31:0] code_word,
  input logic        last_word,
  input logic        stage_valid,
  input logic        stage_stall,
  input logic [2:0]  shader_stage
);

  // No result is offered in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !stage_valid)
    else $error("result valid after reset");

  // Input is only held back while a result waits to be taken.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    code_stall |-> (stage_valid && stage_stall))
    else $error("input stalled without a pending result");

  // Stage codes stay within the defined set.
  a_stage_range: assert property (@(posedge clk) disable iff (rst)
    stage_valid |-> (shader_stage <= STAGE_COMPUTE))
    else $error("stage code out of range");

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && stage_stall) |=> (stage_valid && $stable(shader_stage)))
    else $error("stalled result changed");

  // A stalled word stays offered with the same content.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (code_valid && code_stall) |=>
      (code_valid && $stable(code_word) && $stable(last_word)))
    else $error("stalled input word changed");

endmodule

bind spirv_entry_stage_detect spv_esd_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .code_valid   (code_valid),
  .code_stall   (code_stall),
  .code_word    (code_word),
  .last_word    (last_word),
  .stage_valid  (stage_valid),
  .stage_stall  (stage_stall),
  .shader_stage (shader_stage)
);

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import spv_esd_pkg::*;

  localparam int          WatchdogLimit  = 2000;
  localparam int          DrainCycles    = 20;
  localparam int          StimWords      = 1630;
  localparam int          HoldCycles     = 400;
  localparam int          HoldAtResult   = 30;
  localparam logic [7:0]  OpOther        = 8'd17;
  localparam logic [31:0] ModelVertex    = 32'd0;
  localparam logic [31:0] ModelGLCompute = 32'd5;

  // Reference parser of the stage scan plus the queue of stage codes it expects.
  class stage_scoreboard;
    phase_t      phase;
    logic [2:0]  hdr_pos;
    logic [15:0] skip_left;
    bit          answered;
    stage_t      expected_stages[$];
    int          failures;

    function new();
      rearm();
      failures = 0;
    endfunction

    function void rearm();
      phase     = PH_HEADER;
      hdr_pos   = '0;
      skip_left = '0;
      answered  = 0;
    endfunction

    function int pending();
      return expected_stages.size();
    endfunction

    // Advances the parser by one transferred word and queues a stage code when it ends the scan.
    function void note_word(logic [31:0] word, logic last);
      bit     emit;
      stage_t stage;
      emit  = 0;
      stage = STAGE_UNKNOWN;
      // After a result, words are dropped until the last flag rearms the scan.
      if (answered) begin
        if (last) rearm();
        return;
      end
      case (phase)
        PH_HEADER: begin
          if (hdr_pos == 3'd0 && word != MagicWord) emit = 1;
          else if (last) emit = 1;
          else begin
            hdr_pos = hdr_pos + 3'd1;
            if (hdr_pos >= HeaderWords) begin
              phase     = PH_WALK;
              skip_left = '0;
            end
          end
        end
        PH_MODEL: begin
          emit = 1;
          if (word <= ModelMax) stage = stage_t'(word[2:0] + 3'd1);
        end
        PH_WALK: begin
          if (skip_left != 16'd0) begin
            skip_left = skip_left - 16'd1;
            emit      = last;
          end else if (word[7:0] == OpEntryPoint) begin
            if (last) emit = 1;
            else phase = PH_MODEL;
          end else if (word[31:16] == 16'd0 || last) begin
            emit = 1;
          end else begin
            skip_left = word[31:16] - 16'd1;
          end
        end
        default: emit = 0;
      endcase
      if (emit) begin
        expected_stages.push_back(stage);
        if (last) rearm();
        else answered = 1;
      end
    endfunction

    // Compares one transferred result with the oldest expected stage code.
    function void check_stage(logic [2:0] actual);
      stage_t exp_stage;
      if (expected_stages.size() == 0) begin
        $error("shader_stage: unexpected result, expected none, actual %0d", actual);
        failures++;
        return;
      end
      exp_stage = expected_stages.pop_front();
      if (actual !== exp_stage) begin
        $error("shader_stage: expected %0d, actual %0d", exp_stage, actual);
        failures++;
      end
    endfunction
  endclass

  typedef struct {
    logic [31:0] word;
    logic        last;
  } code_beat_t;

  logic        clk;
  logic        rst;
  logic        code_valid;
  logic        code_stall;
  logic [31:0] code_word;
  logic        last_word;
  logic        stage_valid;
  logic        stage_stall;
  logic [2:0]  shader_stage;

  stage_scoreboard stage_sb = new();
  code_beat_t      module_words[$];
  int              quiet_cycles = 0;

  spirv_entry_stage_detect DUT (
    .clk          (clk),
    .rst          (rst),
    .code_valid   (code_valid),
    .code_stall   (code_stall),
    .code_word    (code_word),
    .last_word    (last_word),
    .stage_valid  (stage_valid),
    .stage_stall  (stage_stall),
    .shader_stage (shader_stage)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic add_word(input logic [31:0] word, input logic last);
    module_words.push_back('{word, last});
  endtask

  // Appends one random module: mostly well formed, the rest cut short, broken or noise.
  task automatic add_random_module();
    int          kind;
    int          start;
    int          len;
    int          cut;
    logic [31:0] w;
    kind  = $urandom_range(0, 99);
    start = module_words.size();
    if (kind >= 90) begin
      repeat ($urandom_range(1, 8)) add_word($urandom(), 1'b0);
      if ($urandom_range(0, 1) == 1) module_words[start].word = MagicWord;
    end else begin
      add_word(MagicWord, 1'b0);
      repeat (4) add_word($urandom(), 1'b0);
      if (kind >= 80 && kind < 85) begin
        // An instruction with a large word count that the last flag cuts off.
        w = $urandom();
        if (w[7:0] == OpEntryPoint) w[7:0] = OpOther;
        if (w[31:16] == 16'd0) w[31] = 1'b1;
        add_word(w, 1'b0);
        repeat ($urandom_range(0, 5)) add_word($urandom(), 1'b0);
      end else begin
        repeat ($urandom_range(0, 5)) begin
          len      = $urandom_range(1, 4);
          w        = $urandom();
          w[31:16] = 16'(len);
          if (w[7:0] == OpEntryPoint) w[7:0] = OpOther;
          add_word(w, 1'b0);
          repeat (len - 1) add_word($urandom(), 1'b0);
        end
        if (kind >= 85) begin
          // A zero word count on an ordinary instruction.
          w        = $urandom();
          w[31:16] = 16'd0;
          if (w[7:0] == OpEntryPoint) w[7:0] = OpOther;
          add_word(w, 1'b0);
        end else begin
          w       = $urandom();
          w[7:0]  = OpEntryPoint;
          add_word(w, 1'b0);
          if ($urandom_range(0, 9) < 8) add_word($urandom_range(0, 5), 1'b0);
          else add_word($urandom(), 1'b0);
        end
        repeat ($urandom_range(0, 4)) add_word($urandom(), 1'b0);
        if (kind >= 65 && kind < 80) begin
          cut = $urandom_range(1, module_words.size() - start);
          while (module_words.size() > start + cut) void'(module_words.pop_back());
        end
      end
    end
    module_words[module_words.size() - 1].last = 1'b1;
  endtask

  // Offers one word after an idle gap and holds it until the transfer.
  task automatic send_word(input code_beat_t beat, input int gap);
    if (gap > 0) begin
      code_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    code_valid <= 1'b1;
    code_word  <= beat.word;
    last_word  <= beat.last;
    @(posedge clk);
    while (code_stall) @(posedge clk);
  endtask

  // Stimulus, reset and the end of the run.
  initial begin
    bit calm;
    rst        <= 1'b1;
    code_valid <= 1'b0;
    code_word  <= '0;
    last_word  <= 1'b0;
    calm       = 0;

    // Wrong magic on a single word, and wrong magic followed by ignored words.
    add_word(32'h0000_0000, 1'b1);
    add_word(32'hFFFF_FFFF, 1'b0);
    add_word(32'h1234_5678, 1'b0);
    add_word(32'hFFFF_FFFF, 1'b1);
    // Last flag inside the header.
    add_word(MagicWord, 1'b0);
    add_word(32'h0000_0000, 1'b0);
    add_word(32'hFFFF_FFFF, 1'b1);
    // Operand skip, then an entry point whose upper opcode bits are set.
    add_word(MagicWord, 1'b0);
    add_word(32'hFFFF_FFFF, 1'b0);
    add_word(32'h0000_0000, 1'b0);
    add_word(32'hAAAA_5555, 1'b0);
    add_word(32'h5555_AAAA, 1'b0);
    add_word({16'd2, 8'h00, OpOther}, 1'b0);
    add_word(32'hFFFF_FFFF, 1'b0);
    add_word({16'hFFFF, 8'hAB, OpEntryPoint}, 1'b0);
    add_word(ModelGLCompute, 1'b0);
    add_word(32'hFFFF_FFFF, 1'b1);
    // Zero word count.
    add_word(MagicWord, 1'b0);
    repeat (4) add_word(32'h0000_0000, 1'b0);
    add_word({16'd0, 8'h00, OpOther}, 1'b0);
    add_word(32'h0000_0000, 1'b1);
    // Entry point on the final word, then a vertex module ending on its model word.
    add_word(MagicWord, 1'b0);
    repeat (4) add_word(32'h0000_0000, 1'b0);
    add_word({16'd4, 8'h00, OpEntryPoint}, 1'b1);
    add_word(MagicWord, 1'b0);
    repeat (4) add_word(32'h0000_0000, 1'b0);
    add_word({16'd4, 8'h00, OpEntryPoint}, 1'b0);
    add_word(ModelVertex, 1'b1);

    while (module_words.size() < StimWords) add_random_module();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (module_words[i]) begin
      if ($urandom_range(0, 39) == 0) calm = !calm;
      send_word(module_words[i], calm ? 0 : $urandom_range(0, 18));
    end
    code_valid <= 1'b0;

    // Let the monitor note the final transfer before looking at the queue.
    @(posedge clk);
    while (stage_sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (stage_sb.failures == 0) begin
      $display("** spirv_entry_stage_detect: PASSED **");
    end else begin
      $display("** spirv_entry_stage_detect: FAILED **");
    end
    $finish;
  end

  // Result side: random stalls, with one long hold-off that backs up the block.
  initial begin
    int wait_cycles;
    int taken;
    bit calm;
    stage_stall <= 1'b0;
    taken       = 0;
    calm        = 0;
    forever begin
      if (taken == HoldAtResult) begin
        wait_cycles = HoldCycles;
      end else begin
        if ($urandom_range(0, 15) == 0) calm = !calm;
        wait_cycles = calm ? 0 : $urandom_range(0, 18);
      end
      if (wait_cycles > 0) begin
        stage_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      stage_stall <= 1'b0;
      do @(posedge clk); while (!stage_valid);
      taken++;
    end
  end

  // Transfer monitor and watchdog.
  always @(posedge clk) begin
    if (!rst) begin
      if (code_valid && !code_stall) stage_sb.note_word(code_word, last_word);
      if (stage_valid && !stage_stall) stage_sb.check_stage(shader_stage);
      if ((code_valid && !code_stall) || (stage_valid && !stage_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("** spirv_entry_stage_detect: FAILED **");
        $finish;
      end
    end
  end

endmodule
